// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEXP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modular exponentiation assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modular exponentiation assertion failed");

`endif

// ----- rtl/mexp_pkg.sv -----
// Package for the modular exponentiation block: widths, reset values and
// configuration register indexes. Depends on nothing.
`default_nettype none

package mexp_pkg;

	localparam int EXP_WIDTH       = 32;
	localparam int DEF_MOD_WIDTH   = 32;
	localparam int DEF_MSG_WIDTH   = 64;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [63:0] RESET_EXPONENT = 64'd17;
	localparam logic [63:0] RESET_MODULUS  = 64'd3233;

	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	localparam cfg_index_t REG_EXPONENT = 2'd0;
	localparam cfg_index_t REG_MODULUS  = 2'd1;

endpackage

`default_nettype wire

// ----- rtl/mexp_modmul.sv -----
// Serial modular multiplier: one operand bit per cycle, double-add-reduce.
// Uses assert_macros.svh; no package dependency.
`default_nettype none

module mexp_modmul #(
	parameter int MOD_WIDTH = 32,
	parameter int OP_WIDTH  = 64,
	parameter int CNT_WIDTH = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [MOD_WIDTH-1:0] a,
	input  wire logic [OP_WIDTH-1:0]  b,
	input  wire logic [CNT_WIDTH-1:0] nbits,
	input  wire logic [MOD_WIDTH-1:0] m,
	output logic                      done,
	output logic [MOD_WIDTH-1:0]      result
);

`include "assert_macros.svh"

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] a_q;
	logic [OP_WIDTH-1:0]  b_q;

	logic [MOD_WIDTH+1:0] sum;
	logic [MOD_WIDTH+1:0] m_one;
	logic [MOD_WIDTH+1:0] m_two;
	logic [MOD_WIDTH+1:0] reduced;
	logic [MOD_WIDTH-1:0] addend;

	// acc < m and a < m, so 2*acc + a stays below 3m: at most two subtractions.
	always_comb begin
		addend  = b_q[OP_WIDTH-1] ? a_q : '0;
		sum     = {1'b0, acc_q, 1'b0} + {2'b00, addend};
		m_one   = {2'b00, m};
		m_two   = {1'b0, m, 1'b0};
		if (sum >= m_two) begin
			reduced = sum - m_two;
		end else if (sum >= m_one) begin
			reduced = sum - m_one;
		end else begin
			reduced = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= reduced[MOD_WIDTH-1:0];
			b_q   <= b_q << 1;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

	`MEXP_ASSERT_IMP(a_acc_below_mod, busy_q, acc_q < m)
	`MEXP_ASSERT_IMP(a_no_restart_busy, start, !busy_q)
	`MEXP_ASSERT_IMP(a_done_when_idle, done_q, !busy_q)

endmodule

`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: configuration registers,
// square-and-multiply sequencer. Depends on mexp_pkg, mexp_modmul and
// assert_macros.svh.
`default_nettype none

// Computes ciphertext = message ^ public_exponent mod modulus, one item at a
// time. An item is taken when start is high and busy is low; the result then
// appears on ciphertext and bad_modulus, marked by done for a single cycle,
// and must be captured in that cycle, since the block cannot be stalled. Each
// item runs through a single serial modular multiplier that handles one
// operand bit per cycle. A first pass reduces the message modulo the modulus;
// then, for exponent e, the multiplier runs floor(log2(e)) squarings and
// popcount(e) multiplications. An exponent of zero gives 1 (or 0 when the
// modulus is 1) after the reduction alone. A zero modulus is answered on the
// cycle after acceptance with bad_modulus high and ciphertext zero. The
// configuration channel is ready only while the block is idle; writes to an
// unknown index are dropped.
module modular_exponentiation #(
	parameter int MOD_WIDTH = mexp_pkg::DEF_MOD_WIDTH,
	parameter int MSG_WIDTH = mexp_pkg::DEF_MSG_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [MSG_WIDTH-1:0]        message,
	output logic                             done,
	output logic [MOD_WIDTH-1:0]             ciphertext,
	output logic                             bad_modulus,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire mexp_pkg::cfg_index_t        cfg_index,
	input  wire logic [((MOD_WIDTH > mexp_pkg::EXP_WIDTH) ? MOD_WIDTH :
		mexp_pkg::EXP_WIDTH)-1:0]        cfg_data
);

`include "assert_macros.svh"

	localparam int EXP_WIDTH = mexp_pkg::EXP_WIDTH;
	// The serial operand register must hold either the message or a residue.
	localparam int OP_WIDTH  = (MSG_WIDTH > MOD_WIDTH) ? MSG_WIDTH : MOD_WIDTH;
	localparam int CNT_WIDTH = $clog2(OP_WIDTH + 1);

	// Sequencer states.
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_REDUCE = 2'd1;
	localparam logic [1:0] S_MUL    = 2'd2;
	localparam logic [1:0] S_SQR    = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           state_d;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [MOD_WIDTH-1:0] mod_q;

	logic [MOD_WIDTH-1:0] product_q;
	logic [MOD_WIDTH-1:0] square_q;
	logic [EXP_WIDTH-1:0] exp_left_q;

	logic                 done_q;
	logic [MOD_WIDTH-1:0] cipher_q;
	logic                 bad_q;

	logic                 in_accept;
	logic                 mod_zero;
	logic [MOD_WIDTH-1:0] one_mod;

	logic                 mm_start;
	logic                 mm_reduce;
	logic [MOD_WIDTH-1:0] mm_a;
	logic [MOD_WIDTH-1:0] mm_b;
	logic [OP_WIDTH-1:0]  mm_b_word;
	logic [CNT_WIDTH-1:0] mm_nbits;
	logic                 mm_done;
	logic [MOD_WIDTH-1:0] mm_result;

	logic                 fin;
	logic [MOD_WIDTH-1:0] fin_value;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign in_accept = start && !busy;
	assign mod_zero  = (mod_q == '0);
	// One reduced modulo the modulus: the starting product, and the multiplier
	// operand that turns the serial pass over the message into a reduction.
	assign one_mod   = (mod_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

	// The sequencer launches the next multiplication in the very cycle the
	// previous one reports done, so the unit never waits between operations.
	// Squaring is skipped once no exponent bits remain, as its result is unused.
	always_comb begin
		mm_start  = 1'b0;
		mm_reduce = 1'b0;
		mm_a      = '0;
		mm_b      = '0;
		fin       = 1'b0;
		fin_value = product_q;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept && !mod_zero) begin
					mm_start  = 1'b1;
					mm_reduce = 1'b1;
					mm_a      = one_mod;
					state_d   = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (mm_done) begin
					if (exp_left_q == '0) begin
						fin       = 1'b1;
						fin_value = product_q;
						state_d   = S_IDLE;
					end else if (exp_left_q[0]) begin
						mm_start = 1'b1;
						mm_a     = product_q;
						mm_b     = mm_result;
						state_d  = S_MUL;
					end else begin
						mm_start = 1'b1;
						mm_a     = mm_result;
						mm_b     = mm_result;
						state_d  = S_SQR;
					end
				end
			end
			S_MUL: begin
				if (mm_done) begin
					if (exp_left_q[EXP_WIDTH-1:1] == '0) begin
						fin       = 1'b1;
						fin_value = mm_result;
						state_d   = S_IDLE;
					end else begin
						mm_start = 1'b1;
						mm_a     = square_q;
						mm_b     = square_q;
						state_d  = S_SQR;
					end
				end
			end
			S_SQR: begin
				// A squaring only runs while higher exponent bits remain, so the
				// shifted exponent is non-zero and its low bit picks the next step.
				if (mm_done) begin
					mm_start = 1'b1;
					if (exp_left_q[1]) begin
						mm_a    = product_q;
						mm_b    = mm_result;
						state_d = S_MUL;
					end else begin
						mm_a    = mm_result;
						mm_b    = mm_result;
						state_d = S_SQR;
					end
				end
			end
		endcase
	end

	// A residue is fed most significant bit first from the top of the operand
	// register; the message fills it from its own top bit.
	assign mm_b_word = mm_reduce ? (OP_WIDTH'(message) << (OP_WIDTH - MSG_WIDTH))
		: (OP_WIDTH'(mm_b) << (OP_WIDTH - MOD_WIDTH));
	assign mm_nbits  = mm_reduce ? CNT_WIDTH'(MSG_WIDTH) : CNT_WIDTH'(MOD_WIDTH);

	mexp_modmul #(
		.MOD_WIDTH (MOD_WIDTH),
		.OP_WIDTH  (OP_WIDTH),
		.CNT_WIDTH (CNT_WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b_word),
		.nbits  (mm_nbits),
		.m      (mod_q),
		.done   (mm_done),
		.result (mm_result)
	);

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			exp_q   <= EXP_WIDTH'(mexp_pkg::RESET_EXPONENT);
			mod_q   <= MOD_WIDTH'(mexp_pkg::RESET_MODULUS);
		end else begin
			state_q <= state_d;
			done_q  <= fin || (in_accept && mod_zero);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mexp_pkg::REG_EXPONENT) begin
					exp_q <= cfg_data[EXP_WIDTH-1:0];
				end else if (cfg_index == mexp_pkg::REG_MODULUS) begin
					mod_q <= cfg_data[MOD_WIDTH-1:0];
				end
			end
		end
	end

	// Working values and the result beat; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_accept && !mod_zero) begin
			product_q  <= one_mod;
			exp_left_q <= exp_q;
		end
		if (mm_done && (state_q == S_REDUCE)) begin
			square_q <= mm_result;
		end
		if (mm_done && (state_q == S_MUL)) begin
			product_q <= mm_result;
		end
		if (mm_done && (state_q == S_SQR)) begin
			square_q   <= mm_result;
			exp_left_q <= exp_left_q >> 1;
		end
		if (fin) begin
			cipher_q <= fin_value;
			bad_q    <= 1'b0;
		end else if (in_accept && mod_zero) begin
			cipher_q <= '0;
			bad_q    <= 1'b1;
		end
	end

	assign done        = done_q;
	assign ciphertext  = cipher_q;
	assign bad_modulus = bad_q;

	`MEXP_ASSERT_IMP(a_done_when_idle, done_q, !busy)
	`MEXP_ASSERT_IMP(a_result_below_mod, done_q && !bad_q, cipher_q < mod_q)
	`MEXP_ASSERT_NEXT(a_zero_mod_flagged, in_accept && mod_zero, done_q && bad_q)

endmodule

`default_nettype wire
